// ----- hdl/dfs_pkg.sv -----
// shared types and constants for the delayed flag scheduler
// used by the interfaces, the front and back parts and the top level
package dfs_pkg;

  localparam int REQ_TYPE_W  = 3;
  localparam int FLAG_IDX_W  = 5;
  localparam int DELAY_W     = 24;
  localparam int FLAG_WORD_W = 32;

  // request codes as they arrive on the input channel
  localparam logic [REQ_TYPE_W-1:0] REQ_SET    = 3'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 3'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_DELAY  = 3'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_CANCEL = 3'd3;
  localparam logic [REQ_TYPE_W-1:0] REQ_TICK   = 3'd4;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_SET,
    OP_CLR,
    OP_SETD,
    OP_CANCEL,
    OP_TICK,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [FLAG_IDX_W-1:0] idx;
    logic [DELAY_W-1:0]    dly;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } bk_state_t;

endpackage

// ----- hdl/dfs_req_if.sv -----
// request channel of the delayed flag scheduler
// depends on dfs_pkg for field widths
interface dfs_req_if import dfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [FLAG_IDX_W-1:0] flag_index;
  logic [DELAY_W-1:0]    delay_ms;

  modport source (output valid, output req_type, output flag_index, output delay_ms,
                  input ready);
  modport sink   (input valid, input req_type, input flag_index, input delay_ms,
                  output ready);
endinterface

// ----- hdl/dfs_rsp_if.sv -----
// result channel of the delayed flag scheduler
// depends on dfs_pkg for field widths
interface dfs_rsp_if import dfs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FLAG_WORD_W-1:0] flag_word;
  logic                   request_dropped;

  modport source (output valid, output flag_word, output request_dropped, input ready);
  modport sink   (input valid, input flag_word, input request_dropped, output ready);
endinterface

// ----- hdl/dfs_front.sv -----
// front part: accepts requests, decodes them into commands, queues them
// depends on dfs_pkg and dfs_req_if
module dfs_front import dfs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  dfs_req_if.sink  req,
  output q_head_t  head,
  input  logic     pop
);

  cmd_t                entry [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wptr;
  logic [Q_PTR_W-1:0]  rptr;
  logic [Q_CNT_W-1:0]  fill;
  logic                push;
  logic                take;
  cmd_t                dec;

  // classify the request
  always_comb begin
    dec.idx = req.flag_index;
    dec.dly = req.delay_ms;
    unique case (req.req_type)
      REQ_SET:    dec.op = OP_SET;
      REQ_CLEAR:  dec.op = OP_CLR;
      REQ_DELAY:  dec.op = OP_SETD;
      REQ_CANCEL: dec.op = OP_CANCEL;
      REQ_TICK:   dec.op = OP_TICK;
      default:    dec.op = OP_NOP;
    endcase
  end

  assign req.ready  = (fill != Q_CNT_W'(Q_DEPTH));
  assign push       = req.valid && req.ready;
  assign take       = pop && (fill != '0);
  assign head.valid = (fill != '0);
  assign head.cmd   = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (take) begin
        rptr <= (rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({push, take})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hdl/dfs_back.sv -----
// back part: flag word, rotating slot ring and result register
// depends on dfs_pkg and dfs_rsp_if
module dfs_back import dfs_pkg::*; #(
  parameter int SLOTS      = 10,
  parameter int FLAG_COUNT = 32,
  parameter int COUNT_BITS = 24
) (
  input  logic      clk,
  input  logic      rst,
  input  q_head_t   head,
  output logic      pop,
  dfs_rsp_if.source rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  bk_state_t               state, state_next;
  logic [FLAG_COUNT-1:0]   flags, flags_next;
  logic                    found, found_next;
  logic [IW-1:0]           widx, widx_next;
  cmd_t                    cmd;

  logic                    slot_active [SLOTS];
  logic [FLAG_IDX_W-1:0]   slot_flag   [SLOTS];
  logic [COUNT_BITS-1:0]   slot_count  [SLOTS];

  logic                    new_act;
  logic [FLAG_IDX_W-1:0]   new_flag;
  logic [COUNT_BITS-1:0]   new_cnt;
  logic [COUNT_BITS-1:0]   cnt_dec;
  logic                    shift_en;
  logic                    load_out;
  logic                    drop_out;
  logic                    out_free;

  logic                    out_valid;
  logic [FLAG_WORD_W-1:0]  out_word;
  logic                    out_drop;

  function automatic logic [FLAG_COUNT-1:0] bit_of(input logic [FLAG_IDX_W-1:0] i);
    logic [FLAG_COUNT-1:0] b;
    b = '0;
    if ({1'b0, i} < (FLAG_IDX_W + 1)'(FLAG_COUNT)) begin
      b = FLAG_COUNT'(1) << i;
    end
    return b;
  endfunction

  assign out_free = !out_valid || rsp.ready;
  assign cnt_dec  = slot_count[0] - COUNT_BITS'(1);

  always_comb begin
    state_next = state;
    flags_next = flags;
    found_next = found;
    widx_next  = widx;
    shift_en   = 1'b0;
    load_out   = 1'b0;
    drop_out   = 1'b0;
    pop        = 1'b0;
    new_act    = slot_active[0];
    new_flag   = slot_flag[0];
    new_cnt    = slot_count[0];
    unique case (state)
      BK_IDLE: begin
        if (head.valid && out_free) begin
          pop = 1'b1;
          unique case (head.cmd.op)
            OP_SET: begin
              flags_next = flags | bit_of(head.cmd.idx);
              load_out   = 1'b1;
            end
            OP_CLR: begin
              flags_next = flags & ~bit_of(head.cmd.idx);
              load_out   = 1'b1;
            end
            OP_NOP: begin
              load_out = 1'b1;
            end
            default: begin
              state_next = BK_WALK;
              widx_next  = '0;
              found_next = 1'b0;
            end
          endcase
        end
      end
      BK_WALK: begin
        shift_en = 1'b1;
        unique case (cmd.op)
          OP_SETD: begin
            if (!found && !slot_active[0]) begin
              new_act    = 1'b1;
              new_flag   = cmd.idx;
              new_cnt    = COUNT_BITS'(cmd.dly);
              found_next = 1'b1;
            end
          end
          OP_CANCEL: begin
            if (!found && slot_flag[0] == cmd.idx) begin
              new_act    = 1'b0;
              new_flag   = '0;
              new_cnt    = '0;
              found_next = 1'b1;
              flags_next = flags & ~bit_of(cmd.idx);
            end
          end
          OP_TICK: begin
            if (slot_active[0]) begin
              new_cnt = cnt_dec;
              if (cnt_dec == '0) begin
                new_act    = 1'b0;
                flags_next = flags | bit_of(slot_flag[0]);
              end
            end
          end
          default: begin
          end
        endcase
        if (widx == IW'(SLOTS - 1)) begin
          load_out   = 1'b1;
          drop_out   = (cmd.op == OP_SETD) && !found_next;
          state_next = BK_IDLE;
        end else begin
          widx_next = widx + 1'b1;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      found     <= 1'b0;
      widx      <= '0;
      out_valid <= 1'b0;
    end else begin
      flags <= flags_next;
      found <= found_next;
      widx  <= widx_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head.cmd;
    end
    if (load_out) begin
      out_word <= FLAG_WORD_W'(flags_next);
      out_drop <= drop_out;
    end
  end

  // ring of slots, head at position 0, rotated once per walk step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_active[i] <= 1'b0;
        slot_flag[i]   <= '0;
        slot_count[i]  <= '0;
      end
    end else if (shift_en) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        slot_active[i] <= slot_active[i+1];
        slot_flag[i]   <= slot_flag[i+1];
        slot_count[i]  <= slot_count[i+1];
      end
      slot_active[SLOTS-1] <= new_act;
      slot_flag[SLOTS-1]   <= new_flag;
      slot_count[SLOTS-1]  <= new_cnt;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.flag_word       = out_word;
  assign rsp.request_dropped = out_drop;

endmodule

// ----- hdl/delayed_flag_scheduler.sv -----
// top level of the delayed flag scheduler
// depends on dfs_pkg, dfs_req_if, dfs_rsp_if, dfs_front and dfs_back
//
// usage
//   req channel: one request per transfer (req_type, flag_index, delay_ms)
//   rsp channel: exactly one result per request, in order (flag_word,
//   request_dropped)
// throughput
//   set, clear and unknown codes: result via the command queue and the output
//   register, one such request per cycle sustained while rsp.ready is high
//   and no walk runs; set-delayed, cancel and tick: the back part walks the
//   slot ring one slot per cycle through a single shared compare/decrement
//   unit and takes no new command until the walk ends
// reset
//   rst clears the flag word, every slot and the command queue; the ring is
//   ready in the first cycle after reset
// stalls
//   a result waits in the output register while rsp.ready is low; the
//   two-entry command queue keeps taking requests until it is full, then
//   req.ready drops
module delayed_flag_scheduler import dfs_pkg::*; #(
  parameter int SLOTS      = 10,
  parameter int FLAG_COUNT = 32,
  parameter int COUNT_BITS = 24
) (
  input  logic      clk,
  input  logic      rst,
  dfs_req_if.sink   req,
  dfs_rsp_if.source rsp
);

  // queue head seen by the back part
  q_head_t head;
  // back part takes the head entry
  logic    pop;

  dfs_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .head (head),
    .pop  (pop)
  );

  dfs_back #(
    .SLOTS      (SLOTS),
    .FLAG_COUNT (FLAG_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule

// ----- hdl/dfs_checker.sv -----
// port-level checks for the delayed flag scheduler, bound to the top level
// depends on dfs_pkg
module dfs_checker import dfs_pkg::*; #(
  parameter int FLAG_COUNT = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [FLAG_WORD_W-1:0] flag_word,
  input logic                   request_dropped
);

  localparam int MAX_OUT = Q_DEPTH + 2;

  logic [2:0] outstanding;
  logic       req_xfer;
  logic       rsp_xfer;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 3'(req_xfer) - 3'(rsp_xfer);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(flag_word) && $stable(request_dropped))
    else $error("result changed while stalled");

  a_unused_bits: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (flag_word >> FLAG_COUNT) == '0)
    else $error("flag bit above flag count set");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    rsp_xfer |-> outstanding != '0)
    else $error("result without a request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 3'(MAX_OUT))
    else $error("more requests in flight than storage");

endmodule

bind delayed_flag_scheduler dfs_checker #(
  .FLAG_COUNT (FLAG_COUNT)
) u_dfs_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .flag_word       (rsp.flag_word),
  .request_dropped (rsp.request_dropped)
);

// ----- tb/sv/tb_delayed_flag_scheduler.sv -----
// self-checking testbench for the delayed flag scheduler: directed table, then random requests
// depends on dfs_pkg, dfs_req_if, dfs_rsp_if and delayed_flag_scheduler from the rtl
module tb_delayed_flag_scheduler;

  timeunit 1ns;
  timeprecision 1ps;

  import dfs_pkg::*;

  localparam int NUM_SLOTS = 10;
  localparam int NUM_FLAGS = 32;
  localparam int COUNT_W   = 24;

  // codes past the last defined request, all of which must be ignored
  localparam logic [REQ_TYPE_W-1:0] REQ_FIRST_UNUSED = REQ_TICK + 3'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_LAST_UNUSED  = '1;

  localparam int RANDOM_PER_PHASE = 188;
  localparam int SETTLE_CYCLES    = 4 * (NUM_SLOTS + 2);
  localparam int STUCK_LIMIT      = 4000;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] kind;
    logic [FLAG_IDX_W-1:0] idx;
    logic [DELAY_W-1:0]    delay;
  } request_t;

  typedef struct packed {
    logic [FLAG_WORD_W-1:0] flags;
    logic                   dropped;
  } flag_result_t;

  typedef struct packed {
    request_t     req;
    logic         typed;   // result written into the table by hand
    flag_result_t res;
  } stim_row_t;

  logic clk;
  logic rst;

  dfs_req_if req_if ();
  dfs_rsp_if rsp_if ();

  delayed_flag_scheduler #(
    .SLOTS      (NUM_SLOTS),
    .FLAG_COUNT (NUM_FLAGS),
    .COUNT_BITS (COUNT_W)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // scheduler model: flag word plus the one-shot slot table
  // --------------------------------------------------------------------------
  logic [FLAG_WORD_W-1:0] sched_flags;
  logic                   slot_armed    [NUM_SLOTS];
  logic [FLAG_IDX_W-1:0]  slot_flag_idx [NUM_SLOTS];
  logic [COUNT_W-1:0]     slot_ticks    [NUM_SLOTS];

  flag_result_t flag_results_due[$];   // results still owed by the dut, oldest first
  stim_row_t    directed_rows[$];

  int tx_idle_pct;    // chance per cycle that the sender holds off
  int rx_stall_pct;   // chance per cycle that the receiver drops ready
  int errors;
  int n_requests;
  int n_ticks;
  int n_drops;
  int n_fires;
  int n_results;

  // one-hot bit of a flag index; indexes past the flag count name no bit
  function automatic logic [FLAG_WORD_W-1:0] flag_bit(input logic [FLAG_IDX_W-1:0] idx);
    if (idx >= NUM_FLAGS) return '0;
    return FLAG_WORD_W'(1) << idx;
  endfunction

  task automatic reset_scheduler_model();
    sched_flags = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_armed[s]    = 1'b0;
      slot_flag_idx[s] = '0;
      slot_ticks[s]    = '0;
    end
  endtask

  // apply one accepted request to the model and return the result it owes
  task automatic schedule_request(input request_t r, output flag_result_t res);
    logic dropped;
    logic matched;
    dropped = 1'b0;
    matched = 1'b0;
    case (r.kind)
      REQ_SET: begin
        sched_flags |= flag_bit(r.idx);
      end
      REQ_CLEAR: begin
        sched_flags &= ~flag_bit(r.idx);
      end
      REQ_DELAY: begin
        // first idle slot wins; a full table drops the request
        dropped = 1'b1;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (dropped && !slot_armed[s]) begin
            slot_armed[s]    = 1'b1;
            slot_flag_idx[s] = r.idx;
            slot_ticks[s]    = COUNT_W'(r.delay);
            dropped          = 1'b0;
          end
        end
      end
      REQ_CANCEL: begin
        // match on the stored index, idle slots included
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (!matched && slot_flag_idx[s] == r.idx) begin
            slot_armed[s]    = 1'b0;
            slot_ticks[s]    = '0;
            slot_flag_idx[s] = '0;
            sched_flags     &= ~flag_bit(r.idx);
            matched          = 1'b1;
          end
        end
      end
      REQ_TICK: begin
        // a zero count wraps to all ones here, so it fires a full period later
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (slot_armed[s]) begin
            slot_ticks[s] = slot_ticks[s] - 1'b1;
            if (slot_ticks[s] == '0) begin
              sched_flags  |= flag_bit(slot_flag_idx[s]);
              slot_armed[s] = 1'b0;
              n_fires++;
            end
          end
        end
      end
      default: ;   // unused codes change nothing
    endcase
    res.flags   = sched_flags;
    res.dropped = dropped;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic add_row(input logic [REQ_TYPE_W-1:0] kind, input logic [FLAG_IDX_W-1:0] idx,
                         input logic [DELAY_W-1:0] delay, input logic typed,
                         input logic [FLAG_WORD_W-1:0] flags, input logic dropped);
    stim_row_t row;
    row.req.kind    = kind;
    row.req.idx     = idx;
    row.req.delay   = delay;
    row.typed       = typed;
    row.res.flags   = flags;
    row.res.dropped = dropped;
    directed_rows.push_back(row);
  endtask

  // mostly low flag indexes so that cancels find their slots; delays mostly short
  // so that slots fire, some zero or huge so that slots stay busy and the table fills
  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 35)      r.kind = REQ_TICK;
    else if (pick < 60) r.kind = REQ_DELAY;
    else if (pick < 75) r.kind = REQ_CANCEL;
    else if (pick < 85) r.kind = REQ_SET;
    else if (pick < 95) r.kind = REQ_CLEAR;
    else                r.kind = REQ_TYPE_W'($urandom_range(REQ_LAST_UNUSED, REQ_FIRST_UNUSED));
    if ($urandom_range(99) < 60) r.idx = FLAG_IDX_W'($urandom_range(7));
    else                         r.idx = FLAG_IDX_W'($urandom());
    pick = $urandom_range(99);
    if (pick < 70)      r.delay = DELAY_W'($urandom_range(8, 1));
    else if (pick < 80) r.delay = '0;
    else if (pick < 95) r.delay = DELAY_W'($urandom());
    else                r.delay = '1;
    return r;
  endfunction

  // offer one request, hold it until the transfer, then log what it owes
  task automatic send_request(input request_t r, input logic typed, input flag_result_t typed_res);
    flag_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= r.kind;
    req_if.flag_index <= r.idx;
    req_if.delay_ms   <= r.delay;
    do @(posedge clk); while (!req_if.ready);
    // transfer at this edge: the model steps here, in acceptance order
    schedule_request(r, predicted);
    flag_results_due.push_back(typed ? typed_res : predicted);
    n_requests++;
    if (r.kind == REQ_TICK) n_ticks++;
    if (predicted.dropped) n_drops++;
  endtask

  // sender goes quiet until every owed result has come back
  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    while (flag_results_due.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [FLAG_WORD_W-1:0] got,
                                 input logic [FLAG_WORD_W-1:0] want);
    $display("%0t ns: mismatch on %s, got %h want %h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_result(input logic [FLAG_WORD_W-1:0] got_flags, input logic got_drop);
    flag_result_t want;
    n_results++;
    if (flag_results_due.size() == 0) begin
      report_mismatch("unexpected result", got_flags, '0);
      return;
    end
    want = flag_results_due.pop_front();
    if (got_flags !== want.flags) report_mismatch("flag_word", got_flags, want.flags);
    if (got_drop !== want.dropped)
      report_mismatch("request_dropped", FLAG_WORD_W'(got_drop), FLAG_WORD_W'(want.dropped));
  endtask

  // receiver: values are taken at the edge, before this edge's updates land
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) check_result(rsp_if.flag_word,
                                                             rsp_if.request_dropped);
      rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog: too many cycles in a row with no transfer on either side
  int stuck_cycles;
  initial begin
    stuck_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles, %0d results still owed", $time,
                 STUCK_LIMIT, flag_results_due.size());
        $display("FAIL delayed_flag_scheduler");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    flag_result_t no_typed;
    errors       = 0;
    n_requests   = 0;
    n_ticks      = 0;
    n_drops      = 0;
    n_fires      = 0;
    n_results    = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    no_typed     = '0;
    reset_scheduler_model();

    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_SET;
    req_if.flag_index <= '0;
    req_if.delay_ms   <= '0;
    rst               <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table: typed results where they are obvious, model elsewhere
    add_row(REQ_TICK,         5'd0,  24'd0,       1'b1, 32'h0000_0000, 1'b0); // tick, empty table
    add_row(REQ_SET,          5'd0,  24'd0,       1'b1, 32'h0000_0001, 1'b0); // lowest flag
    add_row(REQ_SET,          5'd31, 24'd0,       1'b1, 32'h8000_0001, 1'b0); // highest flag
    add_row(REQ_CLEAR,        5'd0,  24'd0,       1'b1, 32'h8000_0000, 1'b0);
    add_row(REQ_FIRST_UNUSED, 5'd3,  24'd0,       1'b1, 32'h8000_0000, 1'b0); // unknown code
    add_row(REQ_LAST_UNUSED,  5'd31, 24'hFF_FFFF, 1'b1, 32'h8000_0000, 1'b0); // unknown code
    add_row(REQ_CLEAR,        5'd31, 24'd0,       1'b1, 32'h0000_0000, 1'b0);
    add_row(REQ_DELAY,        5'd4,  24'd1,       1'b1, 32'h0000_0000, 1'b0); // shortest delay
    add_row(REQ_TICK,         5'd0,  24'd0,       1'b1, 32'h0000_0010, 1'b0); // slot fires
    add_row(REQ_CANCEL,       5'd4,  24'd0,       1'b1, 32'h0000_0000, 1'b0); // hits idle slot
    add_row(REQ_DELAY,        5'd7,  24'hFF_FFFF, 1'b0, '0, 1'b0);             // longest delay
    add_row(REQ_DELAY,        5'd9,  24'd0,       1'b0, '0, 1'b0);             // zero delay
    // fill the remaining slots with staggered delays
    for (int k = 0; k < NUM_SLOTS - 2; k++)
      add_row(REQ_DELAY, FLAG_IDX_W'(10 + k), DELAY_W'(k + 1), 1'b0, '0, 1'b0);
    add_row(REQ_DELAY,        5'd20, 24'd5,       1'b1, 32'h0000_0000, 1'b1); // table full
    add_row(REQ_TICK,         5'd0,  24'd0,       1'b0, '0, 1'b0);             // zero count wraps
    add_row(REQ_CANCEL,       5'd30, 24'd0,       1'b0, '0, 1'b0);             // no match
    add_row(REQ_CANCEL,       5'd7,  24'd0,       1'b0, '0, 1'b0);             // armed slot
    add_row(REQ_TICK,         5'd0,  24'd0,       1'b0, '0, 1'b0);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

    // random part in four handshake modes; each starts from a drained block
    for (int phase = 0; phase < 4; phase++) begin
      wait_for_drain();
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 79; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 79; end
        default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_request(random_request(), 1'b0, no_typed);
    end

    // let everything owed come back, then give the slot walk time to settle
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d ticks, %0d delayed flags fired, %0d dropped)",
             n_requests, n_ticks, n_fires, n_drops);
    $display("checked %0d results across four handshake modes, %0d mismatches",
             n_results, errors);
    if (errors == 0) begin
      $display("PASS delayed_flag_scheduler");
    end else begin
      $display("FAIL delayed_flag_scheduler");
    end
    $finish;
  end

endmodule

// ----- delayed_flag_scheduler.f -----
hdl/dfs_pkg.sv
hdl/dfs_req_if.sv
hdl/dfs_rsp_if.sv
hdl/dfs_front.sv
hdl/dfs_back.sv
hdl/delayed_flag_scheduler.sv
hdl/dfs_checker.sv
tb/sv/tb_delayed_flag_scheduler.sv
